// ===== rtl/core/ppps_pkg.sv =====
// Shared types, codes and constants for the palette pull pixel shifter.
// Used by the cell chain, the blend stage, the top level and the checker.
package ppps_pkg;

	localparam int DistW = 18;
	localparam int ColW  = 24;

	// Operation codes carried in s_tuser.
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [6:0] PctMax = 7'd100;
	localparam logic [7:0] NearBlack = 8'd8;
	localparam logic [7:0] NearWhite = 8'd248;

	// Rounding bias and reciprocal of 100: floor(x / 100) == (x * 5243) >> 19 for x < 25600.
	localparam logic [15:0] RoundBias  = 16'd50;
	localparam logic [12:0] Recip100   = 13'd5243;
	localparam int          RecipShift = 19;

	// Item as it travels along the cell chain.
	typedef struct packed {
		logic             op;
		logic [7:0]       red;
		logic [7:0]       green;
		logic [7:0]       blue;
		logic [3:0]       entry_index;
		logic [DistW-1:0] best_dist;
		logic [3:0]       best_idx;
		logic [ColW-1:0]  best_col;
	} cell_data_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [3:0] nearest_index;
		logic       skip_dither;
	} result_t;

	// Reset value of each palette slot, red in the top byte.
	function automatic logic [ColW-1:0] default_colour(input logic [3:0] idx);
		logic [ColW-1:0] c;
		unique case (idx)
			4'd0:    c = 24'hF8F8F8;
			4'd1:    c = 24'h000000;
			4'd2:    c = 24'hC8C8C8;
			4'd3:    c = 24'h20C840;
			4'd4:    c = 24'h58D878;
			4'd5:    c = 24'h5050E8;
			4'd6:    c = 24'h7870F8;
			4'd7:    c = 24'hD05048;
			4'd8:    c = 24'h40E8F0;
			4'd9:    c = 24'hF85050;
			4'd10:   c = 24'hF87878;
			4'd11:   c = 24'hD0C050;
			4'd12:   c = 24'hE0C880;
			4'd13:   c = 24'h20B038;
			4'd14:   c = 24'hC858B8;
			default: c = 24'h000000;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/core/ppps_cell.sv =====
// One cell of the palette chain: holds one palette entry, compares the passing pixel
// against it and hands the item to the next cell. Depends on ppps_pkg.
module ppps_cell #(
	parameter logic [3:0] CELL_INDEX = 4'd0
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 valid_in,
	input  ppps_pkg::cell_data_t data_in,
	output logic                 valid_out,
	output ppps_pkg::cell_data_t data_out
);
	import ppps_pkg::*;

	logic [ColW-1:0]  entry_q;
	logic             valid_q;
	cell_data_t       data_q;
	cell_data_t       data_d;
	logic [7:0]       dr, dg, db;
	logic [DistW-1:0] dist_sum;
	logic             take;
	logic             load_hit;

	always_comb begin
		dr = (data_in.red   > entry_q[23:16]) ? data_in.red   - entry_q[23:16]
		                                      : entry_q[23:16] - data_in.red;
		dg = (data_in.green > entry_q[15:8])  ? data_in.green - entry_q[15:8]
		                                      : entry_q[15:8]  - data_in.green;
		db = (data_in.blue  > entry_q[7:0])   ? data_in.blue  - entry_q[7:0]
		                                      : entry_q[7:0]   - data_in.blue;
		dist_sum = {2'b00, 16'(dr * dr)} + {2'b00, 16'(dg * dg)} + {2'b00, 16'(db * db)};
		take = dist_sum < data_in.best_dist;
		load_hit = valid_in && (data_in.op == OP_LOAD) && (data_in.entry_index == CELL_INDEX);
	end

	// The item handed on, with this cell's colour taking over on a strictly closer match.
	always_comb begin
		data_d = data_in;
		if (take) begin
			data_d.best_dist = dist_sum;
			data_d.best_idx  = CELL_INDEX;
			data_d.best_col  = entry_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= default_colour(CELL_INDEX);
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
			if (load_hit) begin
				entry_q <= {data_in.red, data_in.green, data_in.blue};
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= data_d;
		end
	end

	assign valid_out = valid_q;
	assign data_out  = data_q;

endmodule

// ===== rtl/core/ppps_blend.sv =====
// Blend stage: pulls each channel toward the chosen palette colour by the percentage,
// rounds half away from zero, and flags near-black or near-white. Depends on ppps_pkg.
module ppps_blend (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic [6:0]           pct,
	input  logic                 valid_in,
	input  ppps_pkg::cell_data_t data_in,
	output logic                 valid_out,
	output ppps_pkg::result_t    result_out
);
	import ppps_pkg::*;

	logic [7:0]  src   [3];
	logic [7:0]  dst   [3];
	logic [7:0]  diff  [3];
	logic        up    [3];
	logic [15:0] mag   [3];

	logic        valid_s1;
	logic [7:0]  src_s1 [3];
	logic        up_s1  [3];
	logic [15:0] mag_s1 [3];
	logic [3:0]  idx_s1;

	logic [28:0] prod [3];
	logic [7:0]  res  [3];
	logic        skip;

	logic        valid_s2;
	result_t     result_s2;

	always_comb begin
		src[0] = data_in.red;
		src[1] = data_in.green;
		src[2] = data_in.blue;
		dst[0] = data_in.best_col[23:16];
		dst[1] = data_in.best_col[15:8];
		dst[2] = data_in.best_col[7:0];
		for (int c = 0; c < 3; c++) begin
			up[c]   = dst[c] >= src[c];
			diff[c] = up[c] ? dst[c] - src[c] : src[c] - dst[c];
			mag[c]  = 16'(diff[c] * pct) + RoundBias;
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			prod[c] = 29'(mag_s1[c] * Recip100);
			res[c]  = up_s1[c] ? src_s1[c] + prod[c][RecipShift+7:RecipShift]
			                   : src_s1[c] - prod[c][RecipShift+7:RecipShift];
		end
		skip = ((res[0] <= NearBlack) && (res[1] <= NearBlack) && (res[2] <= NearBlack)) ||
		       ((res[0] >= NearWhite) && (res[1] >= NearWhite) && (res[2] >= NearWhite));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid_in && (data_in.op == OP_PIXEL);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int c = 0; c < 3; c++) begin
				src_s1[c] <= src[c];
				up_s1[c]  <= up[c];
				mag_s1[c] <= mag[c];
			end
			idx_s1 <= data_in.best_idx;
			result_s2.red           <= res[0];
			result_s2.green         <= res[1];
			result_s2.blue          <= res[2];
			result_s2.nearest_index <= idx_s1;
			result_s2.skip_dither   <= skip;
		end
	end

	assign valid_out  = valid_s2;
	assign result_out = result_s2;

endmodule

// ===== rtl/core/palette_pull_pixel_shifter_unit.sv =====
// Top level of the palette pull pixel shifter: cell chain, blend stage and ports.
// Depends on ppps_pkg, ppps_cell and ppps_blend.
//
// Each item on the slave stream is either a pixel (s_tuser low) or a palette load
// (s_tuser high). Items enter a chain of PALETTE_ENTRIES cells, one cell per cycle;
// every cell holds one palette colour and keeps the nearest colour seen so far, with
// the lowest index winning a tie because a later cell only takes over on a strictly
// smaller distance. A load writes its slot as it passes the matching cell, so pixels
// ahead of it see the old colour and pixels behind it the new one; a load with an
// index at or beyond PALETTE_ENTRIES changes nothing, and loads produce no result.
// After the chain, two blend stages move each channel toward the chosen colour by
// shift_percent (saturated at 100), rounded half away from zero, and flag the pixel
// for skipping dither when all channels are at most 8 or all at least 248.
// The block accepts one item per clock cycle unless the master side stalls; a pixel's
// result is registered in each cell of the chain and then in the two blend registers.
// When the master side stalls, the whole chain holds.
// The palette resets to the default fifteen colours (a sixteenth slot resets to black).
// shift_percent is written on the cfg channel, which is always ready, and must only be
// changed while no pixel is in flight.
module palette_pull_pixel_shifter_unit #(
	parameter int PALETTE_ENTRIES = 15
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,  // shift_percent
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // red_in, green_in, blue_in, entry_index, zero pad
	input  logic        s_tuser,   // operation
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // red_out, green_out, blue_out, nearest_index, zero pad
	output logic        m_tuser    // skip_dither
);
	import ppps_pkg::*;

	logic       en;
	logic [6:0] shift_percent_q;
	logic [6:0] pct;

	logic       chain_valid [PALETTE_ENTRIES+1];
	cell_data_t chain_data  [PALETTE_ENTRIES+1];
	result_t    result;

	// The whole pipeline advances unless a finished result is being held.
	assign en        = !m_tvalid || m_tready;
	assign s_tready  = en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_percent_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			shift_percent_q <= cfg_data;
		end
	end

	assign pct = (shift_percent_q > PctMax) ? PctMax : shift_percent_q;

	// The first cell sees a best distance above any real one, so it always takes over.
	always_comb begin
		chain_valid[0]                = s_tvalid;
		chain_data[0].op              = s_tuser;
		chain_data[0].red             = s_tdata[7:0];
		chain_data[0].green           = s_tdata[15:8];
		chain_data[0].blue            = s_tdata[23:16];
		chain_data[0].entry_index     = s_tdata[27:24];
		chain_data[0].best_dist       = '1;
		chain_data[0].best_idx        = '0;
		chain_data[0].best_col        = '0;
	end

	for (genvar k = 0; k < PALETTE_ENTRIES; k++) begin : g_cell
		ppps_cell #(
			.CELL_INDEX(4'(k))
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (chain_valid[k]),
			.data_in  (chain_data[k]),
			.valid_out(chain_valid[k+1]),
			.data_out (chain_data[k+1])
		);
	end

	ppps_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.pct       (pct),
		.valid_in  (chain_valid[PALETTE_ENTRIES]),
		.data_in   (chain_data[PALETTE_ENTRIES]),
		.valid_out (m_tvalid),
		.result_out(result)
	);

	assign m_tdata = {4'b0000, result.nearest_index, result.blue, result.green, result.red};
	assign m_tuser = result.skip_dither;

endmodule

// ===== rtl/core/ppps_chk.sv =====
// Port-level checker for the palette pull pixel shifter, bound to the top level.
// Depends on ppps_pkg and palette_pull_pixel_shifter_unit.
module ppps_chk #(
	parameter int PALETTE_ENTRIES = 15
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic        m_tuser
);
	import ppps_pkg::*;

	// A held result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// The input side stalls only while a result waits on the output side.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// The skip flag agrees with the delivered channels.
	a_skip: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == (((m_tdata[7:0] <= NearBlack) && (m_tdata[15:8] <= NearBlack)
			&& (m_tdata[23:16] <= NearBlack)) || ((m_tdata[7:0] >= NearWhite)
			&& (m_tdata[15:8] >= NearWhite) && (m_tdata[23:16] >= NearWhite))))
		else $error("skip flag inconsistent with result");

	// The chosen slot always exists and the pad bits stay clear.
	a_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[27:24]) < 32'(PALETTE_ENTRIES)) && (m_tdata[31:28] == 4'b0000))
		else $error("nearest index out of range");

endmodule

bind palette_pull_pixel_shifter_unit ppps_chk #(
	.PALETTE_ENTRIES(PALETTE_ENTRIES)
) u_ppps_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ===== tb/palette_pull_pixel_shifter_unit_test.sv =====
// Self-checking testbench for palette_pull_pixel_shifter_unit: streams pixels and palette loads,
// predicts every result and compares it field by field. Depends on ppps_pkg and the RTL only.
`timescale 1ns / 100ps

module palette_pull_pixel_shifter_unit_test;
	import ppps_pkg::*;

	localparam int Entries      = 15;
	// A pixel's result leaves through the cell chain and the blend stages; loads leave nothing,
	// so after the last result we still give the chain SettleCycles to empty out.
	localparam int PipeDepth    = Entries + 2;
	localparam int SettleCycles = PipeDepth + 4;
	localparam int CycleLimit   = 400000;
	localparam int IdlePct      = 33;
	localparam int PhaseItems   = 250;

	// Reset palette, red in the top byte.
	localparam logic [23:0] DefaultRgb [Entries] = '{
		24'hF8F8F8, 24'h000000, 24'hC8C8C8, 24'h20C840, 24'h58D878,
		24'h5050E8, 24'h7870F8, 24'hD05048, 24'h40E8F0, 24'hF85050,
		24'hF87878, 24'hD0C050, 24'hE0C880, 24'h20B038, 24'hC858B8
	};

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [3:0] nearest_index;
		logic       skip_dither;
	} shade_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data  = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;  // red_in, green_in, blue_in, entry_index, zero pad
	logic        s_tuser   = OP_PIXEL;  // operation
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;         // red_out, green_out, blue_out, nearest_index, zero pad
	logic        m_tuser;         // skip_dither

	// Our own copy of the block's state: palette contents and the blend percentage.
	logic [23:0] palette_rgb [Entries];
	logic [6:0]  shift_pct;
	shade_t      shade_q [$];     // expected results, oldest first
	int          errors = 0;
	int          cycles = 0;
	bit          steady = 1'b0;   // while set, neither side idles

	palette_pull_pixel_shifter_unit #(
		.PALETTE_ENTRIES(Entries)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The receiver stalls about a third of the time unless a steady stretch is running.
	always @(posedge clk) begin
		m_tready <= steady || ($urandom_range(99) >= IdlePct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Nearest palette colour by squared distance, lowest index on a tie, then each channel
	// moved toward it by the saturated percentage, rounded half away from zero.
	function automatic shade_t pull_toward_palette(input logic [7:0] r, g, b);
		int     src [3];
		int     dst [3];
		int     moved [3];
		int     best, best_dist, dist_sq, dr, dg, db, pct;
		shade_t s;
		src = '{int'(r), int'(g), int'(b)};
		best = 0;
		best_dist = 32'h7FFF_FFFF;
		for (int i = 0; i < Entries; i++) begin
			dr = src[0] - int'(palette_rgb[i][23:16]);
			dg = src[1] - int'(palette_rgb[i][15:8]);
			db = src[2] - int'(palette_rgb[i][7:0]);
			dist_sq = dr * dr + dg * dg + db * db;
			// Strictly smaller only, so an earlier slot keeps a tie.
			if (dist_sq < best_dist) begin
				best_dist = dist_sq;
				best = i;
			end
		end
		dst = '{int'(palette_rgb[best][23:16]), int'(palette_rgb[best][15:8]),
			int'(palette_rgb[best][7:0])};
		pct = (shift_pct > PctMax) ? int'(PctMax) : int'(shift_pct);
		for (int c = 0; c < 3; c++) begin
			if (dst[c] >= src[c]) begin
				moved[c] = src[c] + ((dst[c] - src[c]) * pct + 50) / 100;
			end else begin
				moved[c] = src[c] - ((src[c] - dst[c]) * pct + 50) / 100;
			end
		end
		s.red = moved[0][7:0];
		s.green = moved[1][7:0];
		s.blue = moved[2][7:0];
		s.nearest_index = best[3:0];
		s.skip_dither = (moved[0] <= NearBlack && moved[1] <= NearBlack && moved[2] <= NearBlack)
			|| (moved[0] >= NearWhite && moved[1] >= NearWhite && moved[2] >= NearWhite);
		return s;
	endfunction

	// Result checker: every accepted result is compared against the oldest expectation.
	always @(posedge clk) begin
		shade_t got, want;
		if (m_tvalid && m_tready) begin
			got.red = m_tdata[7:0];
			got.green = m_tdata[15:8];
			got.blue = m_tdata[23:16];
			got.nearest_index = m_tdata[27:24];
			got.skip_dither = m_tuser;
			if (shade_q.size() == 0) begin
				$error("result with nothing expected: tdata %h tuser %b", m_tdata, m_tuser);
				errors++;
			end else begin
				want = shade_q.pop_front();
				if (got.red !== want.red) begin
					$error("red_out: expected %0d, got %0d", want.red, got.red);
					errors++;
				end
				if (got.green !== want.green) begin
					$error("green_out: expected %0d, got %0d", want.green, got.green);
					errors++;
				end
				if (got.blue !== want.blue) begin
					$error("blue_out: expected %0d, got %0d", want.blue, got.blue);
					errors++;
				end
				if (got.nearest_index !== want.nearest_index) begin
					$error("nearest_index: expected %0d, got %0d",
						want.nearest_index, got.nearest_index);
					errors++;
				end
				if (got.skip_dither !== want.skip_dither) begin
					$error("skip_dither: expected %0d, got %0d",
						want.skip_dither, got.skip_dither);
					errors++;
				end
			end
		end
	end

	// Sends one item, with a random idle gap in front of it, and updates the prediction
	// once the item has been taken. Valid is left high; the next call or a settle lowers it.
	task automatic send_item(input logic op, input logic [7:0] r, g, b, input logic [3:0] idx);
		while (!steady && $urandom_range(99) < IdlePct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {4'b0000, idx, b, g, r};
		do @(posedge clk); while (!s_tready);
		if (op == OP_LOAD) begin
			// Slots past the end of the palette are ignored by the block.
			if (idx < Entries) palette_rgb[idx] = {r, g, b};
		end else begin
			shade_q.push_back(pull_toward_palette(r, g, b));
		end
	endtask

	// Holds the sender until every expected result has come and the chain has emptied.
	task automatic settle_pipeline();
		s_tvalid <= 1'b0;
		while (shade_q.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_shift_percent(input logic [6:0] pct);
		settle_pipeline();
		cfg_valid <= 1'b1;
		cfg_data <= pct;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		shift_pct = pct;
	endtask

	// Percentage is zero out of reset, so pixels pass through unchanged against the default
	// palette; covers both skip thresholds on each side and a distance tie.
	task automatic test_reset_state();
		send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0, 4'd0);
		send_item(OP_PIXEL, 8'd255, 8'd255, 8'd255, 4'd15);
		send_item(OP_PIXEL, 8'd8, 8'd8, 8'd8, 4'd7);
		send_item(OP_PIXEL, 8'd9, 8'd8, 8'd8, 4'd8);
		send_item(OP_PIXEL, 8'd248, 8'd248, 8'd248, 4'd3);
		send_item(OP_PIXEL, 8'd248, 8'd247, 8'd248, 4'd12);
		// Equally far from slot 0 and slot 2; the lower slot must win.
		send_item(OP_PIXEL, 8'd224, 8'd224, 8'd224, 4'd0);
	endtask

	// Full pull, pull above 100 (saturates), half pull for the rounding, and the smallest step.
	task automatic test_shift_extremes();
		write_shift_percent(7'd100);
		send_item(OP_PIXEL, 8'd130, 8'd60, 8'd200, 4'd1);
		send_item(OP_PIXEL, 8'd224, 8'd224, 8'd224, 4'd2);
		write_shift_percent(7'd127);
		send_item(OP_PIXEL, 8'd130, 8'd60, 8'd200, 4'd4);
		write_shift_percent(7'd50);
		send_item(OP_PIXEL, 8'd1, 8'd0, 8'd0, 4'd5);
		send_item(OP_PIXEL, 8'd247, 8'd255, 8'd255, 4'd9);
		write_shift_percent(7'd1);
		send_item(OP_PIXEL, 8'd0, 8'd255, 8'd128, 4'd14);
	endtask

	// Loads travel in order with pixels: a pixel right behind a load must see the new colour.
	task automatic test_palette_loads();
		send_item(OP_LOAD, 8'h12, 8'h34, 8'h56, 4'd15);  // past the end, ignored
		send_item(OP_PIXEL, 8'h12, 8'h34, 8'h56, 4'd0);
		send_item(OP_LOAD, 8'd255, 8'd0, 8'd255, 4'd14);
		send_item(OP_PIXEL, 8'd255, 8'd0, 8'd255, 4'd14);
		// Duplicate of slot 1's black: the tie still goes to slot 1.
		send_item(OP_LOAD, 8'd0, 8'd0, 8'd0, 4'd5);
		send_item(OP_PIXEL, 8'd0, 8'd0, 8'd0, 4'd6);
		send_item(OP_LOAD, 8'd0, 8'd0, 8'd0, 4'd0);
		send_item(OP_PIXEL, 8'd3, 8'd3, 8'd3, 4'd11);
		send_item(OP_LOAD, 8'd255, 8'd255, 8'd255, 4'd1);
	endtask

	function automatic logic [7:0] jitter(input logic [7:0] c);
		int v;
		v = int'(c) + $urandom_range(12) - 6;
		if (v < 0) v = 0;
		if (v > 255) v = 255;
		return v[7:0];
	endfunction

	// Random phases over a spread of percentages. Pixels are aimed near palette colours and
	// near the skip thresholds often enough to exercise ties and the flag; loads reshape the
	// palette along the way, including the ignored slot.
	task automatic test_random_stream();
		logic [6:0]  pct_plan [8];
		logic [23:0] base;
		logic [7:0]  r, g, b;
		logic [3:0]  idx;
		int          pick;
		bit          dark;
		pct_plan = '{7'd37, 7'd0, 7'd100, 7'd127, 7'd1, 7'd99, 7'd64, 7'($urandom_range(127))};
		for (int phase = 0; phase < 8; phase++) begin
			write_shift_percent(pct_plan[phase]);
			steady = (phase == 3);
			for (int n = 0; n < PhaseItems; n++) begin
				if (phase == 5 && n == PhaseItems / 2) settle_pipeline();
				pick = $urandom_range(99);
				idx = 4'($urandom_range(15));
				if (pick < 8) begin
					send_item(OP_LOAD, 8'($urandom), 8'($urandom), 8'($urandom), idx);
				end else if (pick < 45) begin
					base = palette_rgb[$urandom_range(Entries - 1)];
					if ($urandom_range(3) == 0) begin
						send_item(OP_PIXEL, base[23:16], base[15:8], base[7:0], idx);
					end else begin
						r = jitter(base[23:16]);
						g = jitter(base[15:8]);
						b = jitter(base[7:0]);
						send_item(OP_PIXEL, r, g, b, idx);
					end
				end else if (pick < 60) begin
					dark = $urandom_range(1);
					r = dark ? 8'($urandom_range(12)) : 8'($urandom_range(255, 243));
					g = dark ? 8'($urandom_range(12)) : 8'($urandom_range(255, 243));
					b = dark ? 8'($urandom_range(12)) : 8'($urandom_range(255, 243));
					send_item(OP_PIXEL, r, g, b, idx);
				end else begin
					send_item(OP_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom), idx);
				end
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		for (int i = 0; i < Entries; i++) palette_rgb[i] = DefaultRgb[i];
		shift_pct = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_shift_extremes();
		test_palette_loads();
		test_random_stream();
		settle_pipeline();
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
